// ===== rtl/core/thmq_pkg.sv =====
package thmq_pkg;

   localparam int COORD_W = 24;
   localparam int DIFF_W  = 25;
   localparam int PROD_W  = 50;
   localparam int SUM_W   = 52;
   localparam int WGT_W   = 31;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [1:0] CORNER_0    = 2'd0;
   localparam logic [1:0] CORNER_1    = 2'd1;
   localparam logic [1:0] CORNER_2    = 2'd2;
   localparam logic [1:0] CORNER_NONE = 2'd3;

   localparam logic [1:0] LANE_X  = 2'd0;
   localparam logic [1:0] LANE_Z  = 2'd1;
   localparam logic [1:0] LANE_XZ = 2'd2;

   // phase gains: a full turn is 2^32, c * 2^28 / (2 pi) rounded
   localparam logic [63:0] TWO_PI_E11 = 64'd628318530718;
   localparam logic [63:0] K_X_FULL  =
      (64'd15 * 64'd268435456 * 64'd1000000000 + TWO_PI_E11 / 64'd2) / TWO_PI_E11;
   localparam logic [63:0] K_Z_FULL  =
      (64'd12 * 64'd268435456 * 64'd1000000000 + TWO_PI_E11 / 64'd2) / TWO_PI_E11;
   localparam logic [63:0] K_XZ_FULL =
      (64'd8 * 64'd268435456 * 64'd1000000000 + TWO_PI_E11 / 64'd2) / TWO_PI_E11;
   localparam logic [23:0] K_X  = K_X_FULL[23:0];
   localparam logic [23:0] K_Z  = K_Z_FULL[23:0];
   localparam logic [23:0] K_XZ = K_XZ_FULL[23:0];

   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   localparam logic signed [13:0] AMP_X  = 14'sd4915;
   localparam logic signed [13:0] AMP_Z  = 14'sd3277;
   localparam logic signed [13:0] AMP_XZ = 14'sd1638;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam logic [WGT_W-1:0] ONE_Q30 = 31'h4000_0000;
   localparam logic signed [SUM_W-1:0] DET_EPS = 52'sd1678;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } corner_type;

   typedef corner_type [2:0] row_type;

endpackage

// ===== rtl/core/thmq_if.sv =====
interface thmq_req_if;
   import thmq_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [11:0]               tri_index;
   logic [1:0]                corner;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;
   logic signed [COORD_W-1:0] coord_z;

   modport source (output valid, action, tri_index, corner, coord_x, coord_y, coord_z,
                   input ready);
   modport sink   (input valid, action, tri_index, corner, coord_x, coord_y, coord_z,
                   output ready);
endinterface

interface thmq_rsp_if;
   import thmq_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] height;
   logic                      on_triangle;

   modport source (output valid, height, on_triangle, input ready);
   modport sink   (input valid, height, on_triangle, output ready);
endinterface

// ===== rtl/core/triangle_height_max_query_unit.sv =====
// Load item: accepted while idle, one per cycle.
// Query item: the walk reads one triangle row per cycle from the triangle memory
// and freezes while the weight divider works on each covering triangle.
// One query at a time; loads are taken only between queries.
// Reset (synchronous) clears control only; triangle rows are undefined until loaded.
module triangle_height_max_query_unit #(
   parameter int MAX_TRIANGLES    = 4096,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   thmq_req_if.sink   req_chan,
   thmq_rsp_if.source rsp_chan
);
   import thmq_pkg::*;

   localparam int SLOT_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int CNT_W  = $clog2(MAX_TRIANGLES + 1);
   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PHASE = 3'd1;
   localparam logic [2:0] ST_SINE  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [4:0] DIV_LAST = 5'd29;
   localparam logic [4:0] DIV_MUL  = 5'd30;
   localparam logic [4:0] DIV_ACC  = 5'd31;

   function automatic logic [15:0] sine_entry(input int unsigned k);
      logic [63:0]        t;
      logic [63:0]        t2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] q;
      t = (64'(k) * PI_Q30 + 64'(SINE_TABLE_DEPTH)) / 64'(2 * SINE_TABLE_DEPTH);
      t2 = (t * t) >> 30;
      // Taylor terms up to t^13, alternating in sign
      term = ((t * t2) >> 30) / 64'd6;
      sum  = $signed(t) - $signed(term);
      term = ((term * t2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * t2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * t2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * t2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * t2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      if (sum < 0) sum = 0;
      q = (sum + 64'sd16384) >>> 15;
      if (q > 64'sd32768) q = 64'sd32768;
      return q[15:0];
   endfunction

   logic [15:0] sine_rom [0:SINE_TABLE_DEPTH];
   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
      localparam logic [15:0] ENTRY = sine_entry(k);
      assign sine_rom[k] = ENTRY;
   end

   row_type tri_mem [0:MAX_TRIANGLES-1];

   logic [2:0] state_ff, state_in;
   logic signed [COORD_W-1:0] qx_ff, qz_ff;
   logic [31:0] turn_ff [0:2];
   logic [2:0]  sine_cnt_ff;
   logic [15:0] sine_rd_ff;
   logic        sine_neg_ff, sine_v_ff;
   logic [1:0]  sine_lane_ff;
   logic signed [32:0] tsum_ff;
   logic signed [COORD_W-1:0] h_ff;
   logic hit_ff;
   logic rsp_v_ff;
   logic signed [COORD_W-1:0] rsp_h_ff;
   logic rsp_hit_ff;

   logic [CNT_W-1:0] walk_cnt_ff;
   logic rd_v_ff, d_v_ff, m_v_ff, t_v_ff, busy_ff;
   row_type row_ff;
   logic signed [DIFF_W-1:0] dz23_ff, dx32_ff, dx13_ff, dz31_ff, dz13_ff, px_ff, pz_ff;
   logic signed [COORD_W-1:0] dy_ff [0:2];
   logic signed [PROD_W-1:0] pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   logic signed [COORD_W-1:0] my_ff [0:2];
   logic [SUM_W-1:0] tdet_ff, tn1_ff, tn2_ff;
   logic signed [COORD_W-1:0] ty_ff [0:2];
   logic [SUM_W-1:0] dd_ff, r1_ff, r2_ff;
   logic [29:0] q1_ff, q2_ff;
   logic full1_ff, full2_ff;
   logic [4:0] div_cnt_ff;
   logic signed [COORD_W-1:0] vy_ff [0:2];
   logic signed [55:0] yp_ff [0:2];

   logic adv, issue, walk_empty, load_ok;
   logic [SLOT_W-1:0] load_slot;
   logic [31:0] sel_turn;
   logic [42:0] idx_prod;
   logic [12:0] idx_raw, idx_clip;
   logic [IDX_W-1:0] sine_idx;
   logic signed [16:0] sine_val;
   logic signed [13:0] amp_sel;
   logic signed [SUM_W-1:0] det_s, n1_s, n2_s, det_a, n1_a, n2_a;
   logic signed [SUM_W+1:0] n3_s;
   logic tri_ok;
   logic [SUM_W-1:0] r1_sh, r2_sh;
   logic [WGT_W-1:0] w1, w2, w3;
   logic signed [57:0] acc;
   logic signed [27:0] y_round;
   logic signed [COORD_W-1:0] y_sat;

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_v_ff;
   assign rsp_chan.height      = rsp_h_ff;
   assign rsp_chan.on_triangle = rsp_hit_ff;

   assign adv        = !busy_ff;
   assign issue      = (state_ff == ST_WALK) && adv && (walk_cnt_ff != CNT_W'(MAX_TRIANGLES));
   assign walk_empty = (walk_cnt_ff == CNT_W'(MAX_TRIANGLES)) && !rd_v_ff && !d_v_ff &&
                       !m_v_ff && !t_v_ff && !busy_ff;
   assign load_ok    = ({20'd0, req_chan.tri_index} < 32'(MAX_TRIANGLES));
   assign load_slot  = SLOT_W'(req_chan.tri_index);

   // loads and walk reads never overlap: loads are taken only while idle
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready && req_chan.action == ACT_LOAD && load_ok) begin
         case (req_chan.corner)
            CORNER_0: tri_mem[load_slot][0] <= {req_chan.coord_x, req_chan.coord_y,
                                                req_chan.coord_z};
            CORNER_1: tri_mem[load_slot][1] <= {req_chan.coord_x, req_chan.coord_y,
                                                req_chan.coord_z};
            CORNER_2: tri_mem[load_slot][2] <= {req_chan.coord_x, req_chan.coord_y,
                                                req_chan.coord_z};
            default: ;
         endcase
      end
      if (issue) row_ff <= tri_mem[walk_cnt_ff[SLOT_W-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_chan.valid && req_chan.action == ACT_QUERY) state_in = ST_PHASE;
         ST_PHASE: state_in = ST_SINE;
         ST_SINE:  if (sine_cnt_ff == 3'd4) state_in = ST_WALK;
         ST_WALK:  if (walk_empty) state_in = ST_DONE;
         ST_DONE:  if (!rsp_v_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // terrain: phase lookups
   always_comb begin
      case (sine_cnt_ff[1:0])
         LANE_X:  sel_turn = turn_ff[0];
         LANE_Z:  sel_turn = turn_ff[1];
         default: sel_turn = turn_ff[2];
      endcase
      idx_prod = {13'd0, sel_turn[29:0]} * 43'(SINE_TABLE_DEPTH) + 43'(1 << 29);
      idx_raw  = idx_prod[42:30];
      idx_clip = (idx_raw > 13'(SINE_TABLE_DEPTH)) ? 13'(SINE_TABLE_DEPTH) : idx_raw;
      if (sel_turn[30]) idx_clip = 13'(SINE_TABLE_DEPTH) - idx_clip;
      sine_idx = IDX_W'(idx_clip);
      sine_val = sine_neg_ff ? -$signed({1'b0, sine_rd_ff}) : $signed({1'b0, sine_rd_ff});
      case (sine_lane_ff)
         LANE_X:  amp_sel = AMP_X;
         LANE_Z:  amp_sel = AMP_Z;
         default: amp_sel = AMP_XZ;
      endcase
   end

   // triangle test on the product stage
   always_comb begin
      det_s = SUM_W'(pa_ff) + SUM_W'(pb_ff);
      n1_s  = SUM_W'(pc_ff) + SUM_W'(pd_ff);
      n2_s  = SUM_W'(pe_ff) + SUM_W'(pf_ff);
      det_a = det_s;
      n1_a  = n1_s;
      n2_a  = n2_s;
      if (det_s < 0) begin
         det_a = -det_s;
         n1_a  = -n1_s;
         n2_a  = -n2_s;
      end
      n3_s = (SUM_W+2)'(det_a) - (SUM_W+2)'(n1_a) - (SUM_W+2)'(n2_a);
      tri_ok = (det_a >= DET_EPS) && (n1_a >= 0) && (n1_a <= det_a) &&
               (n2_a >= 0) && (n2_a <= det_a) && (n3_s >= 0) &&
               (n3_s <= (SUM_W+2)'(det_a));
   end

   // weights and interpolation
   always_comb begin
      r1_sh = r1_ff << 1;
      r2_sh = r2_ff << 1;
      w1 = full1_ff ? ONE_Q30 : {1'b0, q1_ff};
      w2 = full2_ff ? ONE_Q30 : {1'b0, q2_ff};
      w3 = ONE_Q30 - w1 - w2;
      acc = 58'(yp_ff[0]) + 58'(yp_ff[1]) + 58'(yp_ff[2]);
      y_round = 28'((acc + 58'sd536870912) >>> 30);
      if (y_round > 28'sd8388607) y_sat = 24'sh7FFFFF;
      else if (y_round < -28'sd8388608) y_sat = -24'sd8388608;
      else y_sat = 24'(y_round);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rsp_v_ff    <= 1'b0;
         rd_v_ff     <= 1'b0;
         d_v_ff      <= 1'b0;
         m_v_ff      <= 1'b0;
         t_v_ff      <= 1'b0;
         busy_ff     <= 1'b0;
         sine_v_ff   <= 1'b0;
         sine_cnt_ff <= 3'd0;
         walk_cnt_ff <= '0;
         div_cnt_ff  <= 5'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && (!rsp_v_ff || rsp_chan.ready)) rsp_v_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_v_ff <= 1'b0;

         sine_v_ff <= (state_ff == ST_SINE) && (sine_cnt_ff < 3'd3);
         if (state_ff == ST_SINE) sine_cnt_ff <= sine_cnt_ff + 3'd1;
         else sine_cnt_ff <= 3'd0;

         if (state_ff == ST_PHASE) begin
            walk_cnt_ff <= '0;
            rd_v_ff     <= 1'b0;
            d_v_ff      <= 1'b0;
            m_v_ff      <= 1'b0;
            t_v_ff      <= 1'b0;
         end else if (adv) begin
            if (issue) walk_cnt_ff <= walk_cnt_ff + CNT_W'(1);
            rd_v_ff <= issue;
            d_v_ff  <= rd_v_ff;
            m_v_ff  <= d_v_ff;
            t_v_ff  <= m_v_ff && tri_ok;
         end

         // take a covering triangle; the walk freezes until it is resolved
         if (t_v_ff && !busy_ff) begin
            busy_ff    <= 1'b1;
            div_cnt_ff <= 5'd0;
         end else if (busy_ff) begin
            div_cnt_ff <= div_cnt_ff + 5'd1;
            if (div_cnt_ff == DIV_ACC) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         qx_ff <= req_chan.coord_x;
         qz_ff <= req_chan.coord_z;
      end

      if (state_ff == ST_PHASE) begin
         turn_ff[0] <= 32'((PROD_W'(qx_ff) * $signed({1'b0, K_X})) >>> 8);
         turn_ff[1] <= 32'((PROD_W'(qz_ff) * $signed({1'b0, K_Z})) >>> 8) + QUARTER_TURN;
         turn_ff[2] <= 32'(((PROD_W'(qx_ff) + PROD_W'(qz_ff)) * $signed({1'b0, K_XZ})) >>> 8);
         tsum_ff <= '0;
         hit_ff  <= 1'b0;
      end

      sine_rd_ff   <= sine_rom[sine_idx];
      sine_neg_ff  <= sel_turn[31];
      sine_lane_ff <= sine_cnt_ff[1:0];
      if (sine_v_ff) tsum_ff <= tsum_ff + 33'(amp_sel * sine_val);
      // terrain sum stays far inside the Q11.12 range, so no saturation
      if (state_ff == ST_SINE && sine_cnt_ff == 3'd4)
         h_ff <= 24'((tsum_ff + 33'sd16384) >>> 15);

      if (adv) begin
         dz23_ff <= DIFF_W'(row_ff[1].z) - DIFF_W'(row_ff[2].z);
         dx32_ff <= DIFF_W'(row_ff[2].x) - DIFF_W'(row_ff[1].x);
         dx13_ff <= DIFF_W'(row_ff[0].x) - DIFF_W'(row_ff[2].x);
         dz31_ff <= DIFF_W'(row_ff[2].z) - DIFF_W'(row_ff[0].z);
         dz13_ff <= DIFF_W'(row_ff[0].z) - DIFF_W'(row_ff[2].z);
         px_ff   <= DIFF_W'(qx_ff) - DIFF_W'(row_ff[2].x);
         pz_ff   <= DIFF_W'(qz_ff) - DIFF_W'(row_ff[2].z);
         pa_ff   <= dz23_ff * dx13_ff;
         pb_ff   <= dx32_ff * dz13_ff;
         pc_ff   <= dz23_ff * px_ff;
         pd_ff   <= dx32_ff * pz_ff;
         pe_ff   <= dz31_ff * px_ff;
         pf_ff   <= dx13_ff * pz_ff;
         tdet_ff <= det_a;
         tn1_ff  <= n1_a;
         tn2_ff  <= n2_a;
         for (int i = 0; i < 3; i++) begin
            dy_ff[i] <= row_ff[i].y;
            my_ff[i] <= dy_ff[i];
            ty_ff[i] <= my_ff[i];
         end
      end

      if (t_v_ff && !busy_ff) begin
         dd_ff    <= tdet_ff;
         r1_ff    <= tn1_ff;
         r2_ff    <= tn2_ff;
         full1_ff <= (tn1_ff == tdet_ff);
         full2_ff <= (tn2_ff == tdet_ff);
         q1_ff    <= '0;
         q2_ff    <= '0;
         for (int i = 0; i < 3; i++) vy_ff[i] <= ty_ff[i];
      end else if (busy_ff) begin
         if (div_cnt_ff <= DIV_LAST) begin
            r1_ff <= (r1_sh >= dd_ff) ? r1_sh - dd_ff : r1_sh;
            r2_ff <= (r2_sh >= dd_ff) ? r2_sh - dd_ff : r2_sh;
            q1_ff <= {q1_ff[28:0], r1_sh >= dd_ff};
            q2_ff <= {q2_ff[28:0], r2_sh >= dd_ff};
         end
         if (div_cnt_ff == DIV_MUL) begin
            yp_ff[0] <= $signed({1'b0, w1}) * vy_ff[0];
            yp_ff[1] <= $signed({1'b0, w2}) * vy_ff[1];
            yp_ff[2] <= $signed({1'b0, w3}) * vy_ff[2];
         end
         if (div_cnt_ff == DIV_ACC && y_sat > h_ff) begin
            h_ff   <= y_sat;
            hit_ff <= 1'b1;
         end
      end

      if (state_ff == ST_DONE && (!rsp_v_ff || rsp_chan.ready)) begin
         rsp_h_ff   <= h_ff;
         rsp_hit_ff <= hit_ff;
      end
   end

`ifndef SYNTHESIS
   a_busy_in_walk: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> state_ff == ST_WALK)
      else $error("divider busy outside the walk");
   a_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> !rd_v_ff && !d_v_ff && !m_v_ff && !t_v_ff && !busy_ff)
      else $error("walk finished with triangles in flight");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the done state");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      walk_cnt_ff <= CNT_W'(MAX_TRIANGLES))
      else $error("walk counter past the table");
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      $past(busy_ff) && busy_ff |-> $stable(walk_cnt_ff))
      else $error("walk advanced while the divider works");
`endif

endmodule

// ===== sim/thmq_checker.sv =====
module thmq_checker (
   input  logic clock,
   input  logic reset,
   thmq_req_if  req_mon,
   thmq_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   hit_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import thmq_pkg::*;

   localparam int SLOTS     = 4096;
   localparam int TAB_DEPTH = 1024;

   typedef struct {
      logic signed [COORD_W-1:0] height;
      logic                      on_triangle;
   } height_result_type;

   logic signed [COORD_W-1:0] corner_x_mem [0:3*SLOTS-1];
   logic signed [COORD_W-1:0] corner_y_mem [0:3*SLOTS-1];
   logic signed [COORD_W-1:0] corner_z_mem [0:3*SLOTS-1];
   longint                    sine_rom [0:TAB_DEPTH];
   height_result_type         height_queue [$];

   function automatic longint clamp24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint sine_at(logic [31:0] turn);
      longint unsigned frac;
      longint unsigned idx;
      longint          v;
      frac = 64'(turn[29:0]);
      idx  = (frac * TAB_DEPTH + (64'd1 << 29)) >> 30;
      if (idx > TAB_DEPTH) idx = TAB_DEPTH;
      if (turn[30]) idx = TAB_DEPTH - idx;
      v = sine_rom[idx];
      return turn[31] ? -v : v;
   endfunction

   function automatic logic [31:0] phase_turn(longint v, logic [23:0] gain);
      logic [63:0] p;
      p = 64'(v) * 64'(gain);
      return p[39:8];
   endfunction

   function automatic longint terrain_height(longint x, longint z);
      longint sum;
      sum = longint'(AMP_X) * sine_at(phase_turn(x, K_X))
          + longint'(AMP_Z) * sine_at(phase_turn(z, K_Z) + QUARTER_TURN)
          + longint'(AMP_XZ) * sine_at(phase_turn(x + z, K_XZ));
      return clamp24((sum + 16384) >>> 15);
   endfunction

   // floor(n * 2^30 / d) by restoring division, capped at 2^30 for n >= d; 0 <= n, d > 0
   function automatic longint weight_frac(longint unsigned n, longint unsigned d);
      longint unsigned r;
      longint unsigned q;
      r = n;
      q = 0;
      if (n >= d) return 64'sd1073741824;
      for (int i = 0; i < 30; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 1;
         end
      end
      return longint'(q);
   endfunction

   function automatic height_result_type max_height(longint qx, longint qz);
      height_result_type res;
      longint h, x1, x2, x3, z1, z2, z3, dz23, dx32, dx13, dz31, px, pz;
      longint det, n1, n2, n3, w1, w2, w3, acc, y;
      int     b;
      h = terrain_height(qx, qz);
      res.on_triangle = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
         b  = 3 * s;
         x1 = corner_x_mem[b]; x2 = corner_x_mem[b+1]; x3 = corner_x_mem[b+2];
         z1 = corner_z_mem[b]; z2 = corner_z_mem[b+1]; z3 = corner_z_mem[b+2];
         dz23 = z2 - z3; dx32 = x3 - x2; dx13 = x1 - x3; dz31 = z3 - z1;
         px = qx - x3; pz = qz - z3;
         det = dz23 * dx13 + dx32 * (z1 - z3);
         n1  = dz23 * px + dx32 * pz;
         n2  = dz31 * px + dx13 * pz;
         if (det < 0) begin
            det = -det; n1 = -n1; n2 = -n2;
         end
         if (det < 1678) continue;
         n3 = det - n1 - n2;
         if (n1 < 0 || n1 > det || n2 < 0 || n2 > det || n3 < 0 || n3 > det) continue;
         w1  = weight_frac(n1, det);
         w2  = weight_frac(n2, det);
         w3  = 64'sd1073741824 - w1 - w2;
         acc = w1 * longint'(corner_y_mem[b]) + w2 * longint'(corner_y_mem[b+1])
             + w3 * longint'(corner_y_mem[b+2]);
         y = clamp24((acc + 64'sd536870912) >>> 30);
         if (y > h) begin
            h = y;
            res.on_triangle = 1'b1;
         end
      end
      res.height = h[23:0];
      return res;
   endfunction

   initial begin
      longint unsigned t, t2, term;
      longint          sum, q;
      for (int k = 0; k <= TAB_DEPTH; k++) begin
         t    = (64'(k) * PI_Q30 + TAB_DEPTH) / (2 * TAB_DEPTH);
         t2   = (t * t) >> 30;
         term = t;
         sum  = longint'(t);
         for (int n = 1; n <= 6; n++) begin
            term = ((term * t2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2) sum -= longint'(term);
            else sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         q = (sum + 16384) >>> 15;
         if (q > 32768) q = 32768;
         sine_rom[k] = q;
      end
      for (int e = 0; e < 3 * SLOTS; e++) begin
         corner_x_mem[e] = '0;
         corner_y_mem[e] = '0;
         corner_z_mem[e] = '0;
      end
   end

   always @(posedge clock) begin
      height_result_type got, want;
      int                e;
      if (reset) begin
         fail_count <= 0;
         pending    <= 0;
         hit_count  <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == ACT_LOAD) begin
               if (req_mon.corner != CORNER_NONE) begin
                  e = 3 * int'(req_mon.tri_index) + int'(req_mon.corner);
                  corner_x_mem[e] = req_mon.coord_x;
                  corner_y_mem[e] = req_mon.coord_y;
                  corner_z_mem[e] = req_mon.coord_z;
               end
            end else begin
               height_queue.push_back(max_height(req_mon.coord_x, req_mon.coord_z));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.height      = rsp_mon.height;
            got.on_triangle = rsp_mon.on_triangle;
            if (height_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected result height=%0d on_triangle=%0b",
                           got.height, got.on_triangle);
               fail_count <= fail_count + 1;
            end else begin
               want = height_queue.pop_front();
               if (want.on_triangle) hit_count <= hit_count + 1;
               if (got.height !== want.height || got.on_triangle !== want.on_triangle) begin
                  if (fail_count < 10)
                     $display("ERROR: height exp %0d got %0d, on_triangle exp %0b got %0b",
                              want.height, got.height, want.on_triangle, got.on_triangle);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= height_queue.size();
      end
   end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import thmq_pkg::*;

   localparam int SLOTS = 4096;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   hit_count;
   int   loads_sent;
   int   queries_sent;

   thmq_req_if req_chan ();
   thmq_rsp_if rsp_chan ();

   triangle_height_max_query_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   thmq_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .hit_count  (hit_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #50ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // hold valid through back-to-back items, lower it only ahead of a gap
   task automatic send_item(logic act, logic [11:0] slot, logic [1:0] cor,
                            logic [23:0] x, logic [23:0] y, logic [23:0] z);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.action    <= act;
      req_chan.tri_index <= slot;
      req_chan.corner    <= cor;
      req_chan.coord_x   <= x;
      req_chan.coord_y   <= y;
      req_chan.coord_z   <= z;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (act == ACT_LOAD) loads_sent++;
      else queries_sent++;
   endtask

   task automatic ask(logic [23:0] x, logic [23:0] z);
      send_item(ACT_QUERY, 12'($urandom()), 2'($urandom()), x, 24'($urandom()), z);
   endtask

   function automatic logic [23:0] near(int span);
      return 24'($urandom_range(0, 2 * span) - span);
   endfunction

   task automatic load_triangle(int slot, bit real_tri);
      int cx, cz;
      logic [23:0] dx, dy, dz;
      cx = $urandom_range(0, 131072) - 65536;
      cz = $urandom_range(0, 131072) - 65536;
      dx = 24'($urandom()); dy = 24'($urandom()); dz = 24'($urandom());
      for (int c = 0; c < 3; c++) begin
         if (real_tri)
            send_item(ACT_LOAD, 12'(slot), 2'(c), 24'(cx) + near(32768), near(81920),
                      24'(cz) + near(32768));
         else
            send_item(ACT_LOAD, 12'(slot), 2'(c), dx, dy, dz);
      end
   endtask

   task automatic load_corner(int slot, logic [1:0] cor, int x, int y, int z);
      send_item(ACT_LOAD, 12'(slot), cor, 24'(x), 24'(y), 24'(z));
   endtask

   initial begin
      int r;
      int items;
      req_chan.valid     = 1'b0;
      req_chan.action    = ACT_LOAD;
      req_chan.tri_index = '0;
      req_chan.corner    = CORNER_0;
      req_chan.coord_x   = '0;
      req_chan.coord_y   = '0;
      req_chan.coord_z   = '0;
      loads_sent   = 0;
      queries_sent = 0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every slot must be written before any query: mostly flat triangles
      for (int s = 0; s < SLOTS; s++)
         load_triangle(s, (s % 170) == 5);

      // just below and exactly at the degenerate threshold, peak at a vertex
      load_corner(1, CORNER_0, 0, 4096, 0);
      load_corner(1, CORNER_1, 1, 4096, 0);
      load_corner(1, CORNER_2, 0, 4096, 1677);
      load_corner(2, CORNER_0, 0, 8388607, 0);
      load_corner(2, CORNER_1, 1, 8388607, 0);
      load_corner(2, CORNER_2, 0, 8388607, 1678);
      // huge triangle far below the terrain everywhere
      load_corner(3, CORNER_0, -8388608, -8388608, -8388608);
      load_corner(3, CORNER_1, 8388607, -8388608, -8388608);
      load_corner(3, CORNER_2, -8388608, -8388608, 8388607);
      send_item(ACT_LOAD, 12'd7, CORNER_NONE, 24'h7fffff, 24'h7fffff, 24'h7fffff);
      ask(24'd0, 24'd0);
      ask(24'd0, 24'd1);
      ask(24'h800000, 24'h800000);
      ask(24'h7fffff, 24'h7fffff);
      ask(24'h800000, 24'h7fffff);
      ask(24'h7fffff, 24'h800000);
      ask(near(65536), near(65536));
      ask(24'd4096, 24'd8192);

      items = 0;
      while (items < 140) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            if ($urandom_range(0, 99) < 15) ask(24'($urandom()), 24'($urandom()));
            else ask(near(98304), near(98304));
            items++;
         end else if (r < 93) begin
            load_triangle($urandom_range(0, SLOTS - 1), $urandom_range(0, 99) < 70);
            items += 3;
         end else begin
            send_item(ACT_LOAD, 12'($urandom()), CORNER_NONE, 24'($urandom()),
                      24'($urandom()), 24'($urandom()));
         end
      end

      req_chan.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d corner loads and %0d height queries", loads_sent, queries_sent);
      $display("%0d queries were raised by a triangle above the terrain", hit_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // result side: long ready stretches, short stalls, now and then a long one
   initial begin
      int hold;
      rsp_chan.ready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            if ($urandom_range(0, 99) < 65) begin
               rsp_chan.ready <= 1'b1;
               hold = $urandom_range(1, 40);
            end else begin
               rsp_chan.ready <= 1'b0;
               hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 3);
            end
         end
         hold--;
      end
   end

endmodule

// ===== triangle_height_max_query_unit.f =====
rtl/core/thmq_pkg.sv
rtl/core/thmq_if.sv
rtl/core/triangle_height_max_query_unit.sv
sim/thmq_checker.sv
sim/tb_top.sv
